FILE: rtl/core/fer_pkg.sv
`default_nettype none

package fer_pkg;

    // page geometry, in pages of 256 bytes
    localparam logic [13:0] PAGES_SECTOR = 14'd16;
    localparam logic [13:0] PAGES_B32    = 14'd128;
    localparam logic [13:0] PAGES_B64    = 14'd256;
    localparam logic [13:0] COUNT_LIMIT  = 14'd8192;

    // erase command bytes
    localparam logic [7:0] OP_SECTOR = 8'h20;
    localparam logic [7:0] OP_B32    = 8'h52;
    localparam logic [7:0] OP_B64    = 8'hD8;

    // one erase request
    typedef struct packed {
        logic [12:0] start_page;
        logic [13:0] page_count;
    } t_req;

    // one erase command
    typedef struct packed {
        logic [7:0]  erase_opcode;
        logic [13:0] erase_page;
        logic        last_command;
    } t_cmd;

    // erase granule chosen by the controller
    typedef enum logic [1:0] {
        SZ_SECTOR,
        SZ_B32,
        SZ_B64
    } t_size;

    // controller to datapath
    typedef struct packed {
        logic  load;
        logic  issue;
        t_size size;
    } t_dp_ctrl;

    // datapath to controller
    typedef struct packed {
        logic left_zero;
        logic left_ge128;
        logic left_ge256;
        logic left_le16;
        logic left_le128;
        logic left_le256;
        logic cur_al128;
        logic cur_al256;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: rtl/core/flash_erase_range_planner.sv
// channel   ports                    transaction
// request   start, busy, i_req       start high while busy low
// command   o_strobe, o_cmd          o_strobe high for one cycle
//
// at most one erase command per cycle from the phase sequencer, and none
// while it changes phase. busy is high from the cycle after acceptance
// until the last command has been registered. reset clears the sequencer
// only. the command side cannot stall: each command shows for exactly
// one cycle.
`default_nettype none

module flash_erase_range_planner #(
    parameter int PAGE_ADDRESS_BITS = 13
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire fer_pkg::t_req i_req,
    output logic               busy,
    output logic               o_strobe,
    output fer_pkg::t_cmd      o_cmd
);

    fer_pkg::t_dp_ctrl w_ctrl;
    fer_pkg::t_dp_stat w_stat;

    // phase sequencer
    fer_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_stat   (w_stat),
        .o_ctrl   (w_ctrl),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    // address and count datapath
    fer_datapath #(
        .PAGE_ADDRESS_BITS (PAGE_ADDRESS_BITS)
    ) u_dp (
        .i_clk  (i_clk),
        .i_req  (i_req),
        .i_ctrl (w_ctrl),
        .o_stat (w_stat),
        .o_cmd  (o_cmd)
    );

endmodule

`default_nettype wire

FILE: rtl/core/fer_datapath.sv
`default_nettype none

module fer_datapath #(
    parameter int PAGE_ADDRESS_BITS = 13
) (
    input  wire logic             i_clk,
    input  wire fer_pkg::t_req    i_req,
    input  wire fer_pkg::t_dp_ctrl i_ctrl,
    output fer_pkg::t_dp_stat     o_stat,
    output fer_pkg::t_cmd         o_cmd
);

    localparam int START_BITS = (PAGE_ADDRESS_BITS < 13) ? PAGE_ADDRESS_BITS : 13;
    localparam logic [12:0] START_MASK = 13'((33'd1 << START_BITS) - 33'd1);

    logic [13:0]   r_cur;
    logic [13:0]   r_left;
    fer_pkg::t_cmd r_cmd;

    logic [13:0] w_size;
    logic [7:0]  w_opcode;
    logic [12:0] w_start;
    logic [13:0] w_count;

    // size and opcode of the selected granule
    always_comb begin
        case (i_ctrl.size)
            fer_pkg::SZ_SECTOR: begin
                w_size   = fer_pkg::PAGES_SECTOR;
                w_opcode = fer_pkg::OP_SECTOR;
            end
            fer_pkg::SZ_B32: begin
                w_size   = fer_pkg::PAGES_B32;
                w_opcode = fer_pkg::OP_B32;
            end
            fer_pkg::SZ_B64: begin
                w_size   = fer_pkg::PAGES_B64;
                w_opcode = fer_pkg::OP_B64;
            end
            default: begin
                w_size   = fer_pkg::PAGES_SECTOR;
                w_opcode = fer_pkg::OP_SECTOR;
            end
        endcase
    end

    // start cut to a sector address within the page address range, count clipped to COUNT_LIMIT
    assign w_start = i_req.start_page & START_MASK & ~13'(fer_pkg::PAGES_SECTOR - 14'd1);
    assign w_count = (i_req.page_count > fer_pkg::COUNT_LIMIT) ? fer_pkg::COUNT_LIMIT
                                                               : i_req.page_count;

    // address and remaining count, command register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cur  <= {1'b0, w_start};
            r_left <= w_count;
        end else if (i_ctrl.issue) begin
            r_cmd.erase_opcode <= w_opcode;
            r_cmd.erase_page   <= r_cur;
            r_cmd.last_command <= (r_left <= w_size);
            r_cur              <= r_cur + w_size;
            r_left             <= (r_left > w_size) ? (r_left - w_size) : 14'd0;
        end
    end

    // status for the controller
    assign o_stat.left_zero  = (r_left == 14'd0);
    assign o_stat.left_ge128 = (r_left >= fer_pkg::PAGES_B32);
    assign o_stat.left_ge256 = (r_left >= fer_pkg::PAGES_B64);
    assign o_stat.left_le16  = (r_left <= fer_pkg::PAGES_SECTOR);
    assign o_stat.left_le128 = (r_left <= fer_pkg::PAGES_B32);
    assign o_stat.left_le256 = (r_left <= fer_pkg::PAGES_B64);
    assign o_stat.cur_al128  = ((r_cur & (fer_pkg::PAGES_B32 - 14'd1)) == 14'd0);
    assign o_stat.cur_al256  = ((r_cur & (fer_pkg::PAGES_B64 - 14'd1)) == 14'd0);

    assign o_cmd = r_cmd;

endmodule

`default_nettype wire

FILE: rtl/core/fer_controller.sv
`default_nettype none

module fer_controller (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire fer_pkg::t_dp_stat i_stat,
    output fer_pkg::t_dp_ctrl      o_ctrl,
    output logic                   o_busy,
    output logic                   o_strobe
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEC_ALIGN,
        ST_B32_ALIGN,
        ST_B64,
        ST_B32_TAIL,
        ST_SEC_TAIL
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   r_strobe, n_strobe;
    fer_pkg::t_dp_ctrl w_ctrl;

    // phase sequencing, one command per cycle at most
    always_comb begin
        n_state      = r_state;
        w_ctrl.load  = 1'b0;
        w_ctrl.issue = 1'b0;
        w_ctrl.size  = fer_pkg::SZ_SECTOR;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    w_ctrl.load = 1'b1;
                    n_state     = ST_SEC_ALIGN;
                end
            end
            ST_SEC_ALIGN: begin
                if (!i_stat.left_zero && !i_stat.cur_al128) begin
                    w_ctrl.issue = 1'b1;
                    w_ctrl.size  = fer_pkg::SZ_SECTOR;
                    if (i_stat.left_le16) n_state = ST_IDLE;
                end else begin
                    n_state = ST_B32_ALIGN;
                end
            end
            ST_B32_ALIGN: begin
                if (!i_stat.left_zero && !i_stat.cur_al256) begin
                    w_ctrl.issue = 1'b1;
                    w_ctrl.size  = fer_pkg::SZ_B32;
                    n_state      = i_stat.left_le128 ? ST_IDLE : ST_B64;
                end else begin
                    n_state = ST_B64;
                end
            end
            ST_B64: begin
                if (i_stat.left_ge256) begin
                    w_ctrl.issue = 1'b1;
                    w_ctrl.size  = fer_pkg::SZ_B64;
                    if (i_stat.left_le256) n_state = ST_IDLE;
                end else begin
                    n_state = ST_B32_TAIL;
                end
            end
            ST_B32_TAIL: begin
                if (i_stat.left_ge128) begin
                    w_ctrl.issue = 1'b1;
                    w_ctrl.size  = fer_pkg::SZ_B32;
                    n_state      = i_stat.left_le128 ? ST_IDLE : ST_SEC_TAIL;
                end else begin
                    n_state = ST_SEC_TAIL;
                end
            end
            ST_SEC_TAIL: begin
                if (!i_stat.left_zero) begin
                    w_ctrl.issue = 1'b1;
                    w_ctrl.size  = fer_pkg::SZ_SECTOR;
                    if (i_stat.left_le16) n_state = ST_IDLE;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_busy   = (n_state != ST_IDLE);
        n_strobe = w_ctrl.issue;
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_strobe <= n_strobe;
        end
    end

    assign o_ctrl   = w_ctrl;
    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;

endmodule

`default_nettype wire
